FILE: rtl/ising_metropolis_sweep_engine_macros.svh
// Assertion macros used by the lattice engine source.
`ifndef ISING_METROPOLIS_SWEEP_ENGINE_MACROS_SVH
`define ISING_METROPOLIS_SWEEP_ENGINE_MACROS_SVH
`ifndef SYNTHESIS
`define IMS_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");
`define IMS_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define IMS_ASSERT_IMPL(label, clk, rstn, ante, cons)
`define IMS_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif
`endif

FILE: rtl/ims_pkg.sv
// ============================================================================
// ims_pkg
// Constants, codes and lattice address helpers of the Ising sweep engine.
// ============================================================================
package ims_pkg;
    localparam int SIDE_W    = 7;
    localparam int SITE_W    = 2 * SIDE_W;
    localparam int NSITES    = 1 << SITE_W;
    localparam int LAG_DEPTH = 256;
    localparam int LAG_W     = 8;

    localparam logic [SITE_W-1:0] SITE_LAST = SITE_W'(NSITES - 1);
    localparam logic [14:0] PM_MULT    = 15'd16807;
    localparam logic [LAG_W-1:0] LAG_START  = 8'd128;
    localparam logic [LAG_W-1:0] LAG_A      = 8'd24;
    localparam logic [LAG_W-1:0] LAG_B      = 8'd55;
    localparam logic [LAG_W-1:0] LAG_C      = 8'd61;
    localparam logic [LAG_W-1:0] FILL_FIRST = 8'd67;
    localparam logic [LAG_W-1:0] FILL_LAST  = 8'd127;
    localparam logic [31:0] HALF_WORD  = 32'h8000_0000;

    localparam logic [30:0] SEED_RST  = 31'd12974236;
    localparam logic [31:0] THR2_RST  = 32'd581260620;
    localparam logic [31:0] THR4_RST  = 32'd78665072;
    localparam logic signed [15:0] MAGNET_RST = -16'sd16384;
    localparam logic signed [16:0] ENERGY_RST = -17'sd32768;

    localparam logic [1:0] REG_SEED = 2'd0;
    localparam logic [1:0] REG_THR2 = 2'd1;
    localparam logic [1:0] REG_THR4 = 2'd2;

    localparam logic [2:0] REQ_WRITE   = 3'd0;
    localparam logic [2:0] REQ_INIT    = 3'd1;
    localparam logic [2:0] REQ_SEQ     = 3'd2;
    localparam logic [2:0] REQ_RAND    = 3'd3;
    localparam logic [2:0] REQ_MEASURE = 3'd4;
    localparam logic [2:0] REQ_READ    = 3'd5;

    localparam logic [2:0] NB_SELF  = 3'd0;
    localparam logic [2:0] NB_UP    = 3'd1;
    localparam logic [2:0] NB_DOWN  = 3'd2;
    localparam logic [2:0] NB_LEFT  = 3'd3;
    localparam logic [2:0] NB_RIGHT = 3'd4;

    // Periodic neighbor of a site; a site index is {y, x}.
    function automatic logic [SITE_W-1:0] nb_addr(input logic [SITE_W-1:0] s,
                                                  input logic [2:0] k);
        logic [SIDE_W-1:0] x;
        logic [SIDE_W-1:0] y;
        x = s[SIDE_W-1:0];
        y = s[SITE_W-1:SIDE_W];
        case (k)
            NB_UP:    y = y - SIDE_W'(1);
            NB_DOWN:  y = y + SIDE_W'(1);
            NB_LEFT:  x = x - SIDE_W'(1);
            NB_RIGHT: x = x + SIDE_W'(1);
            default:  x = x;
        endcase
        return {y, x};
    endfunction
endpackage

FILE: rtl/ims_ram.sv
// ============================================================================
// ims_ram
// Generic RAM with one write port and one registered read port.
// ============================================================================
module ims_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;
endmodule

FILE: rtl/ising_metropolis_sweep_engine.sv
// ============================================================================
// ising_metropolis_sweep_engine
// 2D Ising lattice with Metropolis sweeps under one small sequencer.
// ============================================================================
// The s_ channel takes one request item (write, initialise, sequential sweep,
// random sweep, measure, read); the m_ channel returns one item per request
// with the spin read and the current magnetization and bond energy.
// The APB port holds the seed and the two acceptance thresholds; write it only
// while the block is idle.
// After reset the spin memory is cleared one site per cycle, and s_ready stays
// low meanwhile. One request is in work at a time.
// Each site visit reads the site and its four neighbors through the single
// port of the spin memory, evaluates, draws a random word when needed on the
// single lag table port, and writes back; a random sweep adds a draw and a
// pick per site. Initialise draws the spins and then runs a measure.
// A finished result waits in the output register while the next item is taken;
// if the receiver stalls, that next item waits finished in the sequencer and
// s_ready stays low until the first result leaves.
`include "ising_metropolis_sweep_engine_macros.svh"
module ising_metropolis_sweep_engine (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [3:0]                      paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [2:0]                      s_req_type,
    input  logic [ims_pkg::SITE_W-1:0]      s_site_index,
    input  logic                            s_spin_up,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic                            m_spin_read,
    output logic signed [15:0]              m_magnetization,
    output logic signed [16:0]              m_bond_energy
);
    localparam logic [3:0] ST_CLEAR  = 4'd0;
    localparam logic [3:0] ST_IDLE   = 4'd1;
    localparam logic [3:0] ST_RD     = 4'd2;
    localparam logic [3:0] ST_EVAL   = 4'd3;
    localparam logic [3:0] ST_D0     = 4'd4;
    localparam logic [3:0] ST_D1     = 4'd5;
    localparam logic [3:0] ST_D2     = 4'd6;
    localparam logic [3:0] ST_D3     = 4'd7;
    localparam logic [3:0] ST_ACCEPT = 4'd8;
    localparam logic [3:0] ST_FLIP   = 4'd9;
    localparam logic [3:0] ST_NEXT   = 4'd10;
    localparam logic [3:0] ST_PICK   = 4'd11;
    localparam logic [3:0] ST_PM0    = 4'd12;
    localparam logic [3:0] ST_PM1    = 4'd13;
    localparam logic [3:0] ST_ISPIN  = 4'd14;
    localparam logic [3:0] ST_FIN    = 4'd15;

    localparam int SW = ims_pkg::SITE_W;

    logic [3:0]              state_reg;
    logic [3:0]              ret_reg;
    logic [2:0]              mode_reg;
    logic [SW-1:0]           site_reg;
    logic [SW-1:0]           cnt_reg;
    logic [2:0]              rd_cnt_reg;
    logic                    self_reg;
    logic [2:0]              up_cnt_reg;
    logic                    spin_up_reg;
    logic [31:0]             r_reg;
    logic [31:0]             a_reg;
    logic [31:0]             sum_reg;
    logic [7:0]              ptr_reg;
    logic [7:0]              fill_reg;
    logic [30:0]             pm_reg;
    logic [45:0]             y_reg;
    logic signed [15:0]      magnet_reg;
    logic signed [16:0]      energy_reg;
    logic signed [15:0]      m_acc_reg;
    logic signed [18:0]      e_acc_reg;
    logic [30:0]             seed_reg;
    logic [31:0]             thr2_reg;
    logic [31:0]             thr4_reg;
    logic                    m_valid_reg;
    logic                    spin_out_reg;
    logic                    m_spin_reg;
    logic signed [15:0]      m_magnet_reg;
    logic signed [16:0]      m_energy_reg;

    logic                    spin_we;
    logic [SW-1:0]           spin_waddr;
    logic                    spin_wdata;
    logic [SW-1:0]           spin_raddr;
    logic                    spin_rdata;
    logic                    lag_we;
    logic [7:0]              lag_waddr;
    logic [31:0]             lag_wdata;
    logic [7:0]              lag_raddr;
    logic [31:0]             lag_rdata;
    logic signed [4:0]       nsum;
    logic signed [4:0]       prod;
    logic                    prod_pos;
    logic [31:0]             lag_sum;
    logic [31:0]             pm_v;
    logic [30:0]             pm_new;
    logic                    accept_hit;
    logic signed [18:0]      e_neg;
    logic                    cfg_wr;

    // Neighbor sum is 2*up - 4; the local product carries the site's sign.
    assign nsum     = $signed({1'b0, up_cnt_reg, 1'b0}) - 5'sd4;
    assign prod     = self_reg ? nsum : -nsum;
    assign prod_pos = !prod[4] && (prod != 5'sd0);
    assign lag_sum  = a_reg + lag_rdata;
    assign pm_v     = {1'b0, y_reg[30:0]} + {17'd0, y_reg[45:31]};
    assign pm_new   = pm_v[31] ? (pm_v[30:0] + 31'd1) : pm_v[30:0];
    assign accept_hit = (prod == 5'sd2) ? (r_reg < thr2_reg) : (r_reg < thr4_reg);
    assign e_neg    = -e_acc_reg;

    assign spin_raddr = ims_pkg::nb_addr(site_reg, rd_cnt_reg);
    assign spin_we    = (state_reg == ST_CLEAR) || (state_reg == ST_ISPIN)
                     || (state_reg == ST_FLIP);
    assign spin_waddr = (state_reg == ST_FLIP) ? site_reg : cnt_reg;
    always_comb begin
        case (state_reg)
            ST_ISPIN: spin_wdata = (r_reg > ims_pkg::HALF_WORD);
            ST_FLIP:  spin_wdata = !self_reg;
            default:  spin_wdata = 1'b0;
        endcase
    end

    always_comb begin
        case (state_reg)
            ST_D0:   lag_raddr = ptr_reg - ims_pkg::LAG_A;
            ST_D1:   lag_raddr = ptr_reg - ims_pkg::LAG_B;
            default: lag_raddr = ptr_reg - ims_pkg::LAG_C;
        endcase
    end
    assign lag_we    = (state_reg == ST_D2) || (state_reg == ST_PM1);
    assign lag_waddr = (state_reg == ST_PM1) ? fill_reg : ptr_reg;
    assign lag_wdata = (state_reg == ST_PM1) ? {1'b0, pm_new} : lag_sum;

    ims_ram #(.WIDTH(1), .DEPTH(ims_pkg::NSITES)) u_spin_ram (
        .aclk  (aclk),
        .we    (spin_we),
        .waddr (spin_waddr),
        .wdata (spin_wdata),
        .raddr (spin_raddr),
        .rdata (spin_rdata)
    );

    ims_ram #(.WIDTH(32), .DEPTH(ims_pkg::LAG_DEPTH)) u_lag_ram (
        .aclk  (aclk),
        .we    (lag_we),
        .waddr (lag_waddr),
        .wdata (lag_wdata),
        .raddr (lag_raddr),
        .rdata (lag_rdata)
    );

    // Configuration registers.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    always_comb begin
        case (paddr[3:2])
            ims_pkg::REG_SEED: prdata = {1'b0, seed_reg};
            ims_pkg::REG_THR2: prdata = thr2_reg;
            ims_pkg::REG_THR4: prdata = thr4_reg;
            default:           prdata = 32'd0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seed_reg <= ims_pkg::SEED_RST;
            thr2_reg <= ims_pkg::THR2_RST;
            thr4_reg <= ims_pkg::THR4_RST;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                ims_pkg::REG_SEED: seed_reg <= pwdata[30:0];
                ims_pkg::REG_THR2: thr2_reg <= pwdata;
                ims_pkg::REG_THR4: thr4_reg <= pwdata;
                default:           seed_reg <= seed_reg;
            endcase
        end
    end

    assign s_ready         = (state_reg == ST_IDLE);
    assign m_valid         = m_valid_reg;
    assign m_spin_read     = m_spin_reg;
    assign m_magnetization = m_magnet_reg;
    assign m_bond_energy   = m_energy_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            ret_reg     <= ST_IDLE;
            cnt_reg     <= '0;
            rd_cnt_reg  <= '0;
            ptr_reg     <= ims_pkg::LAG_START;
            pm_reg      <= ims_pkg::SEED_RST;
            magnet_reg  <= ims_pkg::MAGNET_RST;
            energy_reg  <= ims_pkg::ENERGY_RST;
            m_valid_reg <= 1'b0;
        end else begin
            // In the finish state the output register is handled there.
            if (m_valid_reg && m_ready && (state_reg != ST_FIN)) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_CLEAR: begin
                    cnt_reg <= cnt_reg + SW'(1);
                    if (cnt_reg == ims_pkg::SITE_LAST) begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (s_valid) begin
                        mode_reg     <= s_req_type;
                        site_reg     <= ((s_req_type == ims_pkg::REQ_SEQ)
                                         || (s_req_type == ims_pkg::REQ_MEASURE))
                                        ? '0 : s_site_index;
                        spin_up_reg  <= s_spin_up;
                        spin_out_reg <= 1'b0;
                        cnt_reg      <= '0;
                        rd_cnt_reg   <= '0;
                        m_acc_reg    <= '0;
                        e_acc_reg    <= '0;
                        case (s_req_type)
                            ims_pkg::REQ_WRITE, ims_pkg::REQ_READ: begin
                                state_reg <= ST_RD;
                            end
                            ims_pkg::REQ_SEQ, ims_pkg::REQ_MEASURE: begin
                                state_reg <= ST_RD;
                            end
                            ims_pkg::REQ_RAND: begin
                                ret_reg   <= ST_PICK;
                                state_reg <= ST_D0;
                            end
                            ims_pkg::REQ_INIT: begin
                                pm_reg    <= seed_reg;
                                ptr_reg   <= ims_pkg::LAG_START;
                                fill_reg  <= ims_pkg::FILL_FIRST;
                                state_reg <= ST_PM0;
                            end
                            default: begin
                                state_reg <= ST_FIN;
                            end
                        endcase
                    end
                end
                ST_RD: begin
                    // Read k is issued at count k; its data returns at count k+1.
                    if (rd_cnt_reg == 3'd1) begin
                        self_reg   <= spin_rdata;
                        up_cnt_reg <= '0;
                    end else if (rd_cnt_reg >= 3'd2) begin
                        up_cnt_reg <= up_cnt_reg + {2'd0, spin_rdata};
                    end
                    if (rd_cnt_reg == 3'd5) begin
                        state_reg <= ST_EVAL;
                    end else begin
                        rd_cnt_reg <= rd_cnt_reg + 3'd1;
                    end
                end
                ST_EVAL: begin
                    case (mode_reg)
                        ims_pkg::REQ_READ: begin
                            spin_out_reg <= self_reg;
                            state_reg    <= ST_FIN;
                        end
                        ims_pkg::REQ_WRITE: begin
                            state_reg <= (self_reg != spin_up_reg) ? ST_FLIP : ST_FIN;
                        end
                        ims_pkg::REQ_MEASURE: begin
                            m_acc_reg <= m_acc_reg + (self_reg ? 16'sd1 : -16'sd1);
                            e_acc_reg <= e_acc_reg + {{14{prod[4]}}, prod};
                            state_reg <= ST_NEXT;
                        end
                        default: begin
                            if (prod_pos) begin
                                ret_reg   <= ST_ACCEPT;
                                state_reg <= ST_D0;
                            end else begin
                                state_reg <= ST_FLIP;
                            end
                        end
                    endcase
                end
                ST_ACCEPT: begin
                    state_reg <= accept_hit ? ST_FLIP : ST_NEXT;
                end
                ST_FLIP: begin
                    magnet_reg <= magnet_reg + (self_reg ? -16'sd2 : 16'sd2);
                    energy_reg <= energy_reg + {{11{prod[4]}}, prod, 1'b0};
                    state_reg  <= (mode_reg == ims_pkg::REQ_WRITE) ? ST_FIN : ST_NEXT;
                end
                ST_NEXT: begin
                    rd_cnt_reg <= '0;
                    if (cnt_reg == ims_pkg::SITE_LAST) begin
                        if (mode_reg == ims_pkg::REQ_MEASURE) begin
                            magnet_reg <= m_acc_reg;
                            energy_reg <= e_neg[17:1];
                        end
                        state_reg <= ST_FIN;
                    end else begin
                        cnt_reg <= cnt_reg + SW'(1);
                        if (mode_reg == ims_pkg::REQ_RAND) begin
                            ret_reg   <= ST_PICK;
                            state_reg <= ST_D0;
                        end else begin
                            site_reg  <= cnt_reg + SW'(1);
                            state_reg <= ST_RD;
                        end
                    end
                end
                ST_PICK: begin
                    // Random site is the top bits of the word times the site count.
                    site_reg   <= r_reg[31 -: SW];
                    rd_cnt_reg <= '0;
                    state_reg  <= ST_RD;
                end
                ST_D0: begin
                    state_reg <= ST_D1;
                end
                ST_D1: begin
                    a_reg     <= lag_rdata;
                    state_reg <= ST_D2;
                end
                ST_D2: begin
                    sum_reg   <= lag_sum;
                    state_reg <= ST_D3;
                end
                ST_D3: begin
                    r_reg     <= sum_reg ^ lag_rdata;
                    ptr_reg   <= ptr_reg + 8'd1;
                    state_reg <= ret_reg;
                end
                ST_PM0: begin
                    y_reg     <= pm_reg * ims_pkg::PM_MULT;
                    state_reg <= ST_PM1;
                end
                ST_PM1: begin
                    pm_reg <= pm_new;
                    if (fill_reg == ims_pkg::FILL_LAST) begin
                        cnt_reg   <= '0;
                        ret_reg   <= ST_ISPIN;
                        state_reg <= ST_D0;
                    end else begin
                        fill_reg  <= fill_reg + 8'd1;
                        state_reg <= ST_PM0;
                    end
                end
                ST_ISPIN: begin
                    if (cnt_reg == ims_pkg::SITE_LAST) begin
                        // Spins are drawn; the totals are rebuilt by a measure pass.
                        mode_reg   <= ims_pkg::REQ_MEASURE;
                        cnt_reg    <= '0;
                        site_reg   <= '0;
                        rd_cnt_reg <= '0;
                        m_acc_reg  <= '0;
                        e_acc_reg  <= '0;
                        state_reg  <= ST_RD;
                    end else begin
                        cnt_reg   <= cnt_reg + SW'(1);
                        state_reg <= ST_D0;
                    end
                end
                ST_FIN: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg  <= 1'b1;
                        m_spin_reg   <= spin_out_reg;
                        m_magnet_reg <= magnet_reg;
                        m_energy_reg <= energy_reg;
                        state_reg    <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // An even number of sites and of bonds keeps both totals even.
    `IMS_ASSERT_IMPL(a_magnet_even, aclk, aresetn, 1'b1, magnet_reg[0] == 1'b0)
    `IMS_ASSERT_IMPL(a_energy_even, aclk, aresetn, 1'b1, energy_reg[0] == 1'b0)
    `IMS_ASSERT_IMPL(a_rd_cnt_range, aclk, aresetn, state_reg == ST_RD, rd_cnt_reg <= 3'd5)
    `IMS_ASSERT_NEXT(a_accept_leaves_idle, aclk, aresetn, s_valid && s_ready, state_reg != ST_IDLE)
endmodule
